// File: rtl/line_position_estimator_unit_macros.svh
// Assertion macros for the line position estimator.
// The assertions are dropped from synthesis builds.
`ifndef LINE_POSITION_ESTIMATOR_UNIT_MACROS_SVH
`define LINE_POSITION_ESTIMATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define LPE_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line position estimator: assertion failed");
// Check that cons holds in the cycle after ante.
`define LPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line position estimator: assertion failed");
`else
`define LPE_ASSERT_IMPLY(lbl, ante, cons)
`define LPE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/lpe_pkg.sv
package lpe_pkg;

  function automatic int max2(input int a, input int b);
    max2 = (a > b) ? a : b;
  endfunction

  // Array geometry
  localparam int NUM_SENSORS = 5;
  localparam int RAW_BITS    = 12;

  // Scaling
  localparam int FULL_SCALE = 1000;
  localparam int LVL_BITS   = $clog2(FULL_SCALE + 1);
  localparam int POS_MAX    = (NUM_SENSORS - 1) * FULL_SCALE;
  localparam int POS_BITS   = 12;
  localparam int WT_BITS    = $clog2(POS_MAX + 1);
  localparam int SIDX_BITS  = $clog2(NUM_SENSORS);
  localparam int SUM_BITS   = $clog2(NUM_SENSORS * FULL_SCALE + 1);
  localparam int WSUM_BITS  =
    $clog2(FULL_SCALE * FULL_SCALE * ((NUM_SENSORS * (NUM_SENSORS - 1)) / 2) + 1);

  // Serial divider geometry
  localparam int Q_BITS    = max2($clog2(POS_MAX + 1), LVL_BITS);
  localparam int DIV_W     = max2(max2(WSUM_BITS, RAW_BITS + LVL_BITS), SUM_BITS + Q_BITS - 1);
  localparam int STEP_BITS = $clog2(Q_BITS + 1);

  // Stream and configuration widths
  localparam int ACT_BITS      = 2;
  localparam int IN_TDATA_W    = ((NUM_SENSORS * RAW_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W   = ((POS_BITS + 1 + NUM_SENSORS * LVL_BITS + 7) / 8) * 8;
  localparam int THR_BITS      = 10;
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 10;

  // Action codes
  localparam logic [ACT_BITS-1:0] ACT_CLEAR   = 2'd0;
  localparam logic [ACT_BITS-1:0] ACT_SAMPLE  = 2'd1;
  localparam logic [ACT_BITS-1:0] ACT_MEASURE = 2'd2;

  // Register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_LINE_IS_LIGHT   = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_LINE_THRESHOLD  = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_NOISE_THRESHOLD = 2'd2;

  localparam int LINE_TH_RESET  = 200;
  localparam int NOISE_TH_RESET = 50;

  typedef logic [RAW_BITS-1:0]                   raw_t;
  typedef logic [NUM_SENSORS-1:0][RAW_BITS-1:0]  raw_vec_t;
  typedef logic [LVL_BITS-1:0]                   lvl_t;
  typedef logic [NUM_SENSORS-1:0][LVL_BITS-1:0]  lvl_vec_t;
  typedef logic [POS_BITS-1:0]                   pos_t;
  typedef logic [WT_BITS-1:0]                    wt_t;
  typedef logic [SIDX_BITS-1:0]                  sidx_t;
  typedef logic [SUM_BITS-1:0]                   sum_t;
  typedef logic [WSUM_BITS-1:0]                  wsum_t;
  typedef logic [Q_BITS-1:0]                     q_t;
  typedef logic [DIV_W-1:0]                      divw_t;
  typedef logic [STEP_BITS-1:0]                  step_t;
  typedef logic [THR_BITS-1:0]                   thr_t;
  typedef logic [OUT_TDATA_W-1:0]                out_tdata_t;

  // Calibration update request
  typedef struct packed {
    logic clear;
    logic sample;
  } cal_op_t;

  // Divider request: num and den are pre-aligned, den shifted to the top quotient bit
  typedef struct packed {
    logic  start;
    step_t steps;
    divw_t num;
    divw_t den;
  } div_req_t;

  typedef struct packed {
    logic done;
    q_t   quo;
  } div_rsp_t;

  // Centroid weight of a sensor: index times full scale
  function automatic wt_t sensor_weight(input sidx_t idx);
    sensor_weight = wt_t'(int'(idx) * FULL_SCALE);
  endfunction

endpackage

// File: rtl/lpe_div.sv
module lpe_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lpe_pkg::div_req_t req,
  output lpe_pkg::div_rsp_t rsp
);

  lpe_pkg::divw_t rem_r;
  lpe_pkg::divw_t dsr_r;
  lpe_pkg::q_t    quo_r;
  lpe_pkg::step_t cnt_r;
  logic           busy_r;
  logic           done_r;

  logic           ge;
  lpe_pkg::divw_t rem_sub;

  // Trial subtract against the aligned divisor
  always_comb begin
    ge      = rem_r >= dsr_r;
    rem_sub = rem_r - dsr_r;
  end

  // Control: one quotient bit per cycle, pulse done after the last bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == lpe_pkg::step_t'(1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: shift the divisor right, the quotient bits in from the right
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num;
      dsr_r <= req.den;
      cnt_r <= req.steps;
      quo_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_sub;
      end
      dsr_r <= dsr_r >> 1;
      quo_r <= {quo_r[lpe_pkg::Q_BITS-2:0], ge};
      cnt_r <= cnt_r - lpe_pkg::step_t'(1);
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// File: rtl/lpe_cal.sv
module lpe_cal (
  input  logic              clk,
  input  logic              rst_n,
  input  lpe_pkg::cal_op_t  op,
  input  lpe_pkg::raw_vec_t raw,
  input  lpe_pkg::sidx_t    sidx,
  output lpe_pkg::raw_t     lo,
  output lpe_pkg::raw_t     hi
);

  lpe_pkg::raw_vec_t min_r;
  lpe_pkg::raw_vec_t max_r;

  // Clear or widen the bounds of every sensor at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lpe_pkg::NUM_SENSORS; i++) begin
        min_r[i] <= '1;
        max_r[i] <= '0;
      end
    end else if (op.clear) begin
      for (int i = 0; i < lpe_pkg::NUM_SENSORS; i++) begin
        min_r[i] <= '1;
        max_r[i] <= '0;
      end
    end else if (op.sample) begin
      for (int i = 0; i < lpe_pkg::NUM_SENSORS; i++) begin
        if (raw[i] > max_r[i]) begin
          max_r[i] <= raw[i];
        end
        if (raw[i] < min_r[i]) begin
          min_r[i] <= raw[i];
        end
      end
    end
  end

  // Bounds of the sensor under measurement
  assign lo = min_r[sidx];
  assign hi = max_r[sidx];

endmodule

// File: rtl/line_position_estimator_unit.sv
// Line position estimator for a reflectance sensor array.
// Input stream: in_tuser carries the action (clear, calibration sample,
// measure), in_tdata the raw counts of all sensors. Clear and sample
// transactions update the per-sensor minima and maxima in the cycle they
// are accepted and return nothing; the block is ready again the next cycle.
// A measure transaction returns one output transaction with the position,
// the line-seen flag and the calibrated levels.
// A measure takes each sensor in turn: its level is set directly when
// the raw count lies outside the calibration span and divided out
// otherwise, then accumulated; the centroid may need one more division. Both
// run through one shared restoring divider that produces one quotient bit
// per cycle. in_tready is low while a measure runs. The result sits in an
// output register; a stalled receiver holds it there while the next
// transaction is accepted, and a finished measure waits until the register
// is free. Configuration is written through cfg_we, cfg_addr and cfg_wdata;
// write it only while the block is idle; the block does not enforce this.
// Reset empties the calibration bounds, clears the last position and loads
// the default thresholds; no output is pending after reset.
`include "line_position_estimator_unit_macros.svh"

module line_position_estimator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // raw_0 .. raw_(N-1), RAW_BITS each from the lowest bit up, zero padded
  input  logic [lpe_pkg::IN_TDATA_W-1:0]      in_tdata,
  // action
  input  logic [lpe_pkg::ACT_BITS-1:0]        in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // position, line_seen, level_0 .. level_(N-1), from the lowest bit up, zero padded
  output logic [lpe_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [lpe_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [lpe_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LVL   = 3'd1;
  localparam logic [2:0] S_LWAIT = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_CEN   = 3'd4;
  localparam logic [2:0] S_CWAIT = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_r, state_nxt;

  // Configuration
  logic          light_r;
  lpe_pkg::thr_t lth_r;
  lpe_pkg::thr_t nth_r;

  // Measure working set
  lpe_pkg::raw_vec_t raw_r, raw_nxt;
  lpe_pkg::sidx_t    sidx_r, sidx_nxt;
  lpe_pkg::lvl_t     cur_lvl_r, cur_lvl_nxt;
  lpe_pkg::lvl_vec_t lvl_r, lvl_nxt;
  logic              seen_r, seen_nxt;
  lpe_pkg::sum_t     sum_r, sum_nxt;
  lpe_pkg::wsum_t    wsum_r, wsum_nxt;
  lpe_pkg::q_t       pos_r, pos_nxt;
  lpe_pkg::q_t       last_pos_r, last_pos_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  lpe_pkg::pos_t     out_pos_r, out_pos_nxt;
  logic              out_seen_r, out_seen_nxt;
  lpe_pkg::lvl_vec_t out_lvl_r, out_lvl_nxt;

  lpe_pkg::raw_vec_t in_raw;
  logic              in_acc;
  logic              out_free;
  lpe_pkg::cal_op_t  cal_op;
  lpe_pkg::raw_t     cal_lo;
  lpe_pkg::raw_t     cal_hi;
  lpe_pkg::raw_t     cur_raw;
  lpe_pkg::raw_t     span;
  lpe_pkg::raw_t     diff;
  logic [lpe_pkg::RAW_BITS+lpe_pkg::LVL_BITS-1:0] lvl_num;
  logic              span_bad;
  logic              span_sat;
  lpe_pkg::lvl_t     eff_lvl;
  logic [lpe_pkg::LVL_BITS+lpe_pkg::WT_BITS-1:0]  wprod;
  lpe_pkg::div_req_t div_req;
  lpe_pkg::div_rsp_t div_rsp;

  assign in_raw    = in_tdata[lpe_pkg::NUM_SENSORS*lpe_pkg::RAW_BITS-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Calibration updates happen on acceptance
  assign cal_op.clear  = in_acc && (in_tuser == lpe_pkg::ACT_CLEAR);
  assign cal_op.sample = in_acc && (in_tuser == lpe_pkg::ACT_SAMPLE);

  lpe_cal u_cal (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (cal_op),
    .raw   (in_raw),
    .sidx  (sidx_r),
    .lo    (cal_lo),
    .hi    (cal_hi)
  );

  lpe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Scaling terms of the current sensor
  always_comb begin
    cur_raw  = raw_r[sidx_r];
    span     = cal_hi - cal_lo;
    diff     = cur_raw - cal_lo;
    lvl_num  = diff * lpe_pkg::lvl_t'(lpe_pkg::FULL_SCALE);
    span_bad = (cal_hi <= cal_lo) || (cur_raw <= cal_lo);
    span_sat = cur_raw >= cal_hi;
    eff_lvl  = light_r ? (lpe_pkg::lvl_t'(lpe_pkg::FULL_SCALE) - cur_lvl_r) : cur_lvl_r;
    wprod    = eff_lvl * lpe_pkg::sensor_weight(sidx_r);
  end

  // Sequencer: per-sensor level, accumulate, centroid, hand off
  always_comb begin
    state_nxt     = state_r;
    raw_nxt       = raw_r;
    sidx_nxt      = sidx_r;
    cur_lvl_nxt   = cur_lvl_r;
    lvl_nxt       = lvl_r;
    seen_nxt      = seen_r;
    sum_nxt       = sum_r;
    wsum_nxt      = wsum_r;
    pos_nxt       = pos_r;
    last_pos_nxt  = last_pos_r;
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_seen_nxt  = out_seen_r;
    out_lvl_nxt   = out_lvl_r;
    div_req.start = 1'b0;
    div_req.steps = lpe_pkg::step_t'(lpe_pkg::LVL_BITS);
    div_req.num   = lpe_pkg::divw_t'(lvl_num);
    div_req.den   = lpe_pkg::divw_t'({span, {(lpe_pkg::LVL_BITS-1){1'b0}}});

    // Drop the output once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == lpe_pkg::ACT_MEASURE)) begin
          raw_nxt   = in_raw;
          sidx_nxt  = '0;
          seen_nxt  = 1'b0;
          sum_nxt   = '0;
          wsum_nxt  = '0;
          state_nxt = S_LVL;
        end
      end
      S_LVL: begin
        if (span_bad) begin
          cur_lvl_nxt = '0;
          state_nxt   = S_ACC;
        end else if (span_sat) begin
          cur_lvl_nxt = lpe_pkg::lvl_t'(lpe_pkg::FULL_SCALE);
          state_nxt   = S_ACC;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_LWAIT;
        end
      end
      S_LWAIT: begin
        if (div_rsp.done) begin
          cur_lvl_nxt = lpe_pkg::lvl_t'(div_rsp.quo);
          state_nxt   = S_ACC;
        end
      end
      S_ACC: begin
        lvl_nxt[sidx_r] = cur_lvl_r;
        if (eff_lvl > lth_r) begin
          seen_nxt = 1'b1;
        end
        if (eff_lvl > nth_r) begin
          wsum_nxt = wsum_r + lpe_pkg::wsum_t'(wprod);
          sum_nxt  = sum_r + lpe_pkg::sum_t'(eff_lvl);
        end
        if (sidx_r == lpe_pkg::sidx_t'(lpe_pkg::NUM_SENSORS - 1)) begin
          state_nxt = S_CEN;
        end else begin
          sidx_nxt  = sidx_r + lpe_pkg::sidx_t'(1);
          state_nxt = S_LVL;
        end
      end
      S_CEN: begin
        div_req.steps = lpe_pkg::step_t'(lpe_pkg::Q_BITS);
        div_req.num   = lpe_pkg::divw_t'(wsum_r);
        div_req.den   = lpe_pkg::divw_t'({sum_r, {(lpe_pkg::Q_BITS-1){1'b0}}});
        if (!seen_r) begin
          // No line: report the edge on the side it was last seen
          pos_nxt   = (last_pos_r < lpe_pkg::q_t'(lpe_pkg::POS_MAX / 2)) ?
                      '0 : lpe_pkg::q_t'(lpe_pkg::POS_MAX);
          state_nxt = S_FIN;
        end else if (sum_r == '0) begin
          // Nothing above noise: repeat the last position
          pos_nxt   = last_pos_r;
          state_nxt = S_FIN;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_CWAIT;
        end
      end
      S_CWAIT: begin
        div_req.steps = lpe_pkg::step_t'(lpe_pkg::Q_BITS);
        if (div_rsp.done) begin
          last_pos_nxt = div_rsp.quo;
          pos_nxt      = div_rsp.quo;
          state_nxt    = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = lpe_pkg::pos_t'(pos_r);
          out_seen_nxt  = seen_r;
          out_lvl_nxt   = lvl_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_pos_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_pos_r  <= last_pos_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    raw_r      <= raw_nxt;
    sidx_r     <= sidx_nxt;
    cur_lvl_r  <= cur_lvl_nxt;
    lvl_r      <= lvl_nxt;
    seen_r     <= seen_nxt;
    sum_r      <= sum_nxt;
    wsum_r     <= wsum_nxt;
    pos_r      <= pos_nxt;
    out_pos_r  <= out_pos_nxt;
    out_seen_r <= out_seen_nxt;
    out_lvl_r  <= out_lvl_nxt;
  end

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r <= 1'b0;
      lth_r   <= lpe_pkg::thr_t'(lpe_pkg::LINE_TH_RESET);
      nth_r   <= lpe_pkg::thr_t'(lpe_pkg::NOISE_TH_RESET);
    end else if (cfg_we) begin
      case (cfg_addr)
        lpe_pkg::REG_LINE_IS_LIGHT:   light_r <= cfg_wdata[0];
        lpe_pkg::REG_LINE_THRESHOLD:  lth_r   <= cfg_wdata[lpe_pkg::THR_BITS-1:0];
        lpe_pkg::REG_NOISE_THRESHOLD: nth_r   <= cfg_wdata[lpe_pkg::THR_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = lpe_pkg::out_tdata_t'({out_lvl_r, out_seen_r, out_pos_r});

  // Divider results only arrive while the sequencer waits for them
  `LPE_ASSERT_IMPLY(a_div_done_in_wait, div_rsp.done, (state_r == S_LWAIT) || (state_r == S_CWAIT))
  // An accepted measure starts with the first sensor
  `LPE_ASSERT_NEXT(a_measure_starts, in_acc && (in_tuser == lpe_pkg::ACT_MEASURE), (state_r == S_LVL) && (sidx_r == '0))
  // A finished measure lands in the output register
  `LPE_ASSERT_NEXT(a_fin_loads_out, (state_r == S_FIN) && out_free, out_valid_r && (state_r == S_IDLE))
  // A reported position stays within the array
  `LPE_ASSERT_IMPLY(a_pos_in_range, out_valid_r, out_pos_r <= lpe_pkg::pos_t'(lpe_pkg::POS_MAX))

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lpe_pkg::*;

  // Action code the block leaves unused
  localparam logic [ACT_BITS-1:0] ACT_UNUSED = 2'd3;

  // Cycles to let pass after the last result; longer than a full measure
  localparam int SETTLE_CYCLES = 100;
  // Cycles without any transaction before the run is declared hung
  localparam int STUCK_LIMIT   = 4000;

  // Expected result of one measure, laid out as out_tdata
  typedef struct packed {
    lvl_vec_t level;
    logic     seen;
    pos_t     position;
  } line_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_TDATA_W-1:0]    in_tdata = '0;
  logic [ACT_BITS-1:0]      in_tuser = ACT_CLEAR;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]   out_tdata;
  logic                     cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = REG_LINE_IS_LIGHT;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // Shadow configuration and calibration state of the estimator
  bit          light_line = 1'b0;
  int unsigned line_th    = LINE_TH_RESET;
  int unsigned noise_th   = NOISE_TH_RESET;
  raw_t        cal_lo[NUM_SENSORS] = '{default: '1};
  raw_t        cal_hi[NUM_SENSORS] = '{default: '0};
  int unsigned last_pos   = 0;

  line_result_t positions_due[$];

  // Idling knobs, in percent
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  int unsigned err_count    = 0;
  int unsigned result_count = 0;
  int unsigned meas_count   = 0;
  int unsigned cal_count    = 0;
  int unsigned skip_count   = 0;
  int unsigned reg_writes   = 0;
  int unsigned stuck_cycles = 0;

  line_position_estimator_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Compute the result of a measure and advance the last position
  function automatic line_result_t predict_measure(input raw_vec_t raw);
    line_result_t r;
    int unsigned  lvl;
    int unsigned  v;
    int unsigned  wsum;
    int unsigned  total;
    logic         seen;
    wsum  = 0;
    total = 0;
    seen  = 1'b0;
    r     = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (cal_hi[i] <= cal_lo[i] || raw[i] <= cal_lo[i]) begin
        lvl = 0;
      end else begin
        lvl = ((raw[i] - cal_lo[i]) * FULL_SCALE) / (cal_hi[i] - cal_lo[i]);
        if (lvl > FULL_SCALE) lvl = FULL_SCALE;
      end
      r.level[i] = lvl_t'(lvl);
      v = light_line ? FULL_SCALE - lvl : lvl;
      if (v > line_th) seen = 1'b1;
      if (v > noise_th) begin
        wsum  += v * (i * FULL_SCALE);
        total += v;
      end
    end
    if (!seen) begin
      r.position = (last_pos < POS_MAX / 2) ? pos_t'(0) : pos_t'(POS_MAX);
    end else begin
      if (total != 0) last_pos = wsum / total;
      r.position = pos_t'(last_pos);
    end
    r.seen = seen;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    err_count++;
    if (err_count <= 20)
      $display("MISMATCH result %0d %s: got %0d, expected %0d",
               result_count, what, got, want);
  endtask

  // Track every accepted input transaction in the shadow state
  always @(posedge clk) begin
    raw_vec_t raw;
    if (rst_n && in_tvalid && in_tready) begin
      raw = raw_vec_t'(in_tdata[NUM_SENSORS*RAW_BITS-1:0]);
      case (in_tuser)
        ACT_CLEAR: begin
          cal_count++;
          for (int i = 0; i < NUM_SENSORS; i++) begin
            cal_lo[i] = '1;
            cal_hi[i] = '0;
          end
        end
        ACT_SAMPLE: begin
          cal_count++;
          for (int i = 0; i < NUM_SENSORS; i++) begin
            if (raw[i] > cal_hi[i]) cal_hi[i] = raw[i];
            if (raw[i] < cal_lo[i]) cal_lo[i] = raw[i];
          end
        end
        ACT_MEASURE: begin
          meas_count++;
          positions_due.push_back(predict_measure(raw));
        end
        default: skip_count++;
      endcase
    end
  end

  // Compare each output transaction with the oldest expectation
  always @(posedge clk) begin
    line_result_t got;
    line_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = line_result_t'(out_tdata[$bits(line_result_t)-1:0]);
      if (positions_due.size() == 0) begin
        flag_mismatch("unexpected result, position", 32'(got.position), 0);
      end else begin
        want = positions_due.pop_front();
        if (got.position != want.position)
          flag_mismatch("position", 32'(got.position), 32'(want.position));
        if (got.seen != want.seen)
          flag_mismatch("line_seen", 32'(got.seen), 32'(want.seen));
        for (int i = 0; i < NUM_SENSORS; i++)
          if (got.level[i] != want.level[i])
            flag_mismatch($sformatf("level_%0d", i), 32'(got.level[i]),
                          32'(want.level[i]));
      end
      result_count++;
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Run hung with %0d results outstanding", positions_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Send one item, holding it until the block takes it
  task automatic send_item(input logic [ACT_BITS-1:0] act, input raw_vec_t raw);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= IN_TDATA_W'(raw);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Wait until every result is back and the block has gone quiet
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (positions_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; the caller releases the write enable
  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= CFG_DATA_BITS'(val);
    @(posedge clk);
    reg_writes++;
    case (addr)
      REG_LINE_IS_LIGHT:   light_line = val[0];
      REG_LINE_THRESHOLD:  line_th    = val;
      REG_NOISE_THRESHOLD: noise_th   = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input bit light, input int unsigned lth, input int unsigned nth);
    drain_results();
    write_reg(REG_LINE_IS_LIGHT, 32'(light));
    write_reg(REG_LINE_THRESHOLD, lth);
    write_reg(REG_NOISE_THRESHOLD, nth);
    // Release the write port after the last register
    cfg_we <= 1'b0;
  endtask

  function automatic raw_vec_t mk_raw(input int unsigned r0, input int unsigned r1,
                                      input int unsigned r2, input int unsigned r3,
                                      input int unsigned r4);
    return {raw_t'(r4), raw_t'(r3), raw_t'(r2), raw_t'(r1), raw_t'(r0)};
  endfunction

  // Threshold with the extremes drawn often
  function automatic int unsigned pick_threshold();
    int unsigned k;
    k = $urandom_range(9);
    if (k < 2) return 0;
    if (k < 4) return FULL_SCALE;
    return $urandom_range(FULL_SCALE);
  endfunction

  // Raw count around a calibration window, sometimes outside it
  function automatic raw_t pick_raw(input int unsigned lo, input int unsigned span);
    int v;
    if ($urandom_range(9) == 0) return raw_t'($urandom);
    v = int'(lo) + int'($urandom_range(span + span / 2)) - int'(span / 4);
    if (v < 0) v = 0;
    if (v > (1 << RAW_BITS) - 1) v = (1 << RAW_BITS) - 1;
    return raw_t'(v);
  endfunction

  // Measure before any calibration: empty spans, no line, unused action
  task automatic test_power_on();
    send_item(ACT_MEASURE, mk_raw(4095, 4095, 4095, 4095, 4095));
    send_item(ACT_UNUSED, mk_raw(4095, 0, 4095, 0, 4095));
    send_item(ACT_MEASURE, mk_raw(0, 0, 0, 0, 0));
    drain_results();
  endtask

  // Full-range and degenerate calibration spans, position extremes
  task automatic test_calibration_edges();
    send_item(ACT_CLEAR, mk_raw(0, 0, 0, 0, 0));
    send_item(ACT_SAMPLE, mk_raw(0, 0, 0, 0, 0));
    send_item(ACT_SAMPLE, mk_raw(4095, 4095, 4095, 4095, 4095));
    send_item(ACT_MEASURE, mk_raw(0, 4095, 2048, 1, 4094));
    send_item(ACT_MEASURE, mk_raw(4095, 0, 0, 0, 0));
    send_item(ACT_MEASURE, mk_raw(0, 0, 0, 0, 4095));
    send_item(ACT_MEASURE, mk_raw(0, 0, 0, 0, 0));
    send_item(ACT_CLEAR, mk_raw(4095, 4095, 4095, 4095, 4095));
    send_item(ACT_SAMPLE, mk_raw(100, 100, 100, 100, 100));
    send_item(ACT_MEASURE, mk_raw(100, 200, 50, 4095, 0));
    send_item(ACT_SAMPLE, mk_raw(200, 300, 400, 500, 600));
    send_item(ACT_MEASURE, mk_raw(150, 300, 50, 4095, 350));
    drain_results();
  endtask

  // Light line, line seen with nothing above noise, nothing seen at full scale
  task automatic test_thresholds();
    set_config(1'b1, LINE_TH_RESET, NOISE_TH_RESET);
    send_item(ACT_MEASURE, mk_raw(0, 0, 0, 0, 0));
    set_config(1'b0, 0, FULL_SCALE);
    send_item(ACT_MEASURE, mk_raw(150, 300, 400, 500, 600));
    set_config(1'b0, FULL_SCALE, 0);
    send_item(ACT_MEASURE, mk_raw(4095, 4095, 4095, 4095, 4095));
    set_config(1'b1, 999, 999);
    send_item(ACT_MEASURE, mk_raw(100, 4095, 4095, 4095, 4095));
    set_config(1'b0, LINE_TH_RESET, NOISE_TH_RESET);
  endtask

  // Calibrate-then-measure sequences with random content, plus broken ones
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned gap,
                                     input int unsigned stall);
    int unsigned sent;
    int unsigned seq_no;
    int unsigned kind;
    int unsigned n;
    int unsigned center;
    int unsigned win_lo[NUM_SENSORS];
    int unsigned win_span[NUM_SENSORS];
    raw_vec_t    raw;
    sent   = 0;
    seq_no = 0;
    set_config(1'($urandom_range(1)), pick_threshold(), pick_threshold());
    gap_pct   = gap;
    stall_pct = stall;
    while (sent < n_items) begin
      seq_no++;
      if (seq_no % 4 == 0)
        set_config(1'($urandom_range(1)), pick_threshold(), pick_threshold());
      kind = $urandom_range(99);
      if (kind < 80) begin
        // Pick a calibration window per sensor: wide, mid or narrow
        for (int i = 0; i < NUM_SENSORS; i++) begin
          case ($urandom_range(2))
            0: win_span[i] = $urandom_range(4095);
            1: win_span[i] = $urandom_range(400);
            default: win_span[i] = $urandom_range(16);
          endcase
          win_lo[i] = $urandom_range(4095 - win_span[i]);
        end
        send_item(ACT_CLEAR, raw_vec_t'({$urandom, $urandom}));
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) begin
          for (int i = 0; i < NUM_SENSORS; i++)
            raw[i] = raw_t'(win_lo[i] + $urandom_range(win_span[i]));
          send_item(ACT_SAMPLE, raw);
        end
        sent += n + 1;
        n = $urandom_range(5, 25);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(2) == 0) begin
            // Line profile: dark near one sensor, light elsewhere
            center = $urandom_range(NUM_SENSORS - 1);
            for (int i = 0; i < NUM_SENSORS; i++) begin
              if (i == center || (i + 1 == center) || (i == center + 1 && $urandom_range(1)))
                raw[i] = pick_raw(win_lo[i] + win_span[i] / 2, win_span[i] / 2);
              else
                raw[i] = pick_raw(win_lo[i], win_span[i] / 4);
            end
          end else begin
            for (int i = 0; i < NUM_SENSORS; i++) raw[i] = pick_raw(win_lo[i], win_span[i]);
          end
          send_item(ACT_MEASURE, raw);
        end
        sent += n;
      end else if (kind < 92) begin
        // Broken sequence: actions in any order with random counts
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
          kind = $urandom_range(3);
          send_item(ACT_BITS'(kind), raw_vec_t'({$urandom, $urandom}));
          if (kind != ACT_UNUSED) sent++;
        end
      end else begin
        // Ignored items between measures on the standing calibration
        send_item(ACT_UNUSED, raw_vec_t'({$urandom, $urandom}));
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) send_item(ACT_MEASURE, raw_vec_t'({$urandom, $urandom}));
        sent += n;
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_power_on();
    test_calibration_edges();
    test_thresholds();
    test_random_traffic(325, 0, 0);
    test_random_traffic(325, 58, 0);
    test_random_traffic(325, 0, 58);
    test_random_traffic(325, 30, 30);
    drain_results();
    $display("Covered %0d calibration and %0d measure transactions, %0d ignored, %0d results,",
             cal_count, meas_count, skip_count, result_count);
    $display("%0d register writes, across four idling phases; %0d mismatches",
             reg_writes, err_count);
    if (err_count == 0 && positions_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
